// ===== design/pse_pkg.sv =====
package pse_pkg;

  // Store geometry and number formats
  localparam int unsigned MaxDegree  = 31;
  localparam int unsigned StoreDepth = MaxDegree + 1;
  localparam int unsigned ExpWidth   = $clog2(StoreDepth);
  localparam int unsigned KWidth     = ExpWidth + 1;
  localparam int unsigned CoefWidth  = 32;
  localparam int unsigned AccWidth   = 64;
  localparam int unsigned KindWidth  = 3;

  // Stream payload layout, lowest field first
  localparam int unsigned InAmtLsb     = ExpWidth;
  localparam int unsigned InPaLsb      = InAmtLsb + CoefWidth;
  localparam int unsigned InPbLsb      = InPaLsb + CoefWidth;
  localparam int unsigned InDataWidth  = ((InPbLsb + CoefWidth + 7) / 8) * 8;
  localparam int unsigned OutDegLsb    = CoefWidth;
  localparam int unsigned OutZeroBit   = OutDegLsb + ExpWidth;
  localparam int unsigned OutSatBit    = OutZeroBit + 1;
  localparam int unsigned OutDataWidth = ((OutSatBit + 1 + 7) / 8) * 8;

  // Item kinds
  typedef logic [KindWidth-1:0] kind_t;
  localparam kind_t KindAssign = 3'd0;
  localparam kind_t KindAdd    = 3'd1;
  localparam kind_t KindClear  = 3'd2;
  localparam kind_t KindEval   = 3'd3;
  localparam kind_t KindInteg  = 3'd4;
  localparam kind_t KindRead   = 3'd5;

  // Saturation limits
  localparam logic signed [CoefWidth-1:0] CoefMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoefWidth-1:0] CoefMin = 32'sh8000_0000;
  localparam logic signed [AccWidth-1:0]  AccMax  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [AccWidth-1:0]  AccMin  = 64'sh8000_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_RDW,
    ST_WB,
    ST_DEG,
    ST_PASS,
    ST_MAG,
    ST_MUL,
    ST_RND,
    ST_DIV,
    ST_ADD,
    ST_FIN,
    ST_DONE
  } pse_state_e;

  // Horner step strobes
  typedef struct packed {
    logic init;
    logic clr_sat;
    logic mag_en;
    logic mul_en;
    logic rnd_en;
    logic add_en;
  } mac_ctrl_t;

  // Antiderivative divider strobes
  typedef struct packed {
    logic ld;
    logic mul;
    logic fix;
  } div_ctrl_t;

  // floor((2^32 - 1) / k); quotient estimate is low by at most one
  function automatic logic [31:0] recip(input logic [KWidth-1:0] k);
    logic [31:0] r;
    case (k)
      6'd1:    r = 32'hFFFF_FFFF;
      6'd2:    r = 32'h7FFF_FFFF;
      6'd3:    r = 32'h5555_5555;
      6'd4:    r = 32'h3FFF_FFFF;
      6'd5:    r = 32'h3333_3333;
      6'd6:    r = 32'h2AAA_AAAA;
      6'd7:    r = 32'h2492_4924;
      6'd8:    r = 32'h1FFF_FFFF;
      6'd9:    r = 32'h1C71_C71C;
      6'd10:   r = 32'h1999_9999;
      6'd11:   r = 32'h1745_D174;
      6'd12:   r = 32'h1555_5555;
      6'd13:   r = 32'h13B1_3B13;
      6'd14:   r = 32'h1249_2492;
      6'd15:   r = 32'h1111_1111;
      6'd16:   r = 32'h0FFF_FFFF;
      6'd17:   r = 32'h0F0F_0F0F;
      6'd18:   r = 32'h0E38_E38E;
      6'd19:   r = 32'h0D79_435E;
      6'd20:   r = 32'h0CCC_CCCC;
      6'd21:   r = 32'h0C30_C30C;
      6'd22:   r = 32'h0BA2_E8BA;
      6'd23:   r = 32'h0B21_642C;
      6'd24:   r = 32'h0AAA_AAAA;
      6'd25:   r = 32'h0A3D_70A3;
      6'd26:   r = 32'h09D8_9D89;
      6'd27:   r = 32'h097B_425E;
      6'd28:   r = 32'h0924_9249;
      6'd29:   r = 32'h08D3_DCB0;
      6'd30:   r = 32'h0888_8888;
      6'd31:   r = 32'h0842_1084;
      6'd32:   r = 32'h07FF_FFFF;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

  // Highest set bit of the nonzero mask, 0 when the mask is empty
  function automatic logic [ExpWidth-1:0] top_index(input logic [StoreDepth-1:0] mask);
    logic [ExpWidth-1:0] idx;
    idx = '0;
    for (int i = 0; i < StoreDepth; i++) begin
      if (mask[i]) idx = ExpWidth'(i);
    end
    return idx;
  endfunction

endpackage

// ===== design/pse_ram.sv =====
module pse_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrWidth = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/pse_div.sv =====
module pse_div (
  input  logic                                 clk_i,
  input  pse_pkg::div_ctrl_t                   ctrl_i,
  input  logic signed [pse_pkg::CoefWidth-1:0] coef_i,
  input  logic [pse_pkg::KWidth-1:0]           k_i,
  output logic signed [pse_pkg::CoefWidth-1:0] term_o
);

  import pse_pkg::*;

  logic                  cneg_q;
  logic [CoefWidth-1:0]  n_q;
  logic [KWidth-1:0]     k_q;
  logic [CoefWidth-1:0]  q0_q;
  logic [CoefWidth-1:0]  term_q;

  logic [CoefWidth-1:0]   cmag;
  logic [2*CoefWidth-1:0] est;
  logic [CoefWidth+KWidth-1:0] qk;
  logic [CoefWidth-1:0]   rem;
  logic [CoefWidth-1:0]   q;

  // rounded magnitude quotient: (|c| + k/2) / k by reciprocal and one correction
  always_comb begin
    cmag = coef_i[CoefWidth-1] ? (CoefWidth'(0) - unsigned'(coef_i)) : unsigned'(coef_i);
    est  = (2*CoefWidth)'(n_q) * (2*CoefWidth)'(recip(k_q));
    qk   = (CoefWidth+KWidth)'(q0_q) * (CoefWidth+KWidth)'(k_q);
    rem  = n_q - qk[CoefWidth-1:0];
    q    = q0_q + CoefWidth'(rem >= CoefWidth'(k_q));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld) begin
      cneg_q <= coef_i[CoefWidth-1];
      n_q    <= cmag + CoefWidth'(k_i[KWidth-1:1]);
      k_q    <= k_i;
    end
    if (ctrl_i.mul) q0_q <= est[2*CoefWidth-1:CoefWidth];
    if (ctrl_i.fix) term_q <= cneg_q ? (CoefWidth'(0) - q) : q;
  end

  assign term_o = signed'(term_q);

endmodule

// ===== design/pse_mac.sv =====
module pse_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pse_pkg::mac_ctrl_t                   ctrl_i,
  input  logic signed [pse_pkg::CoefWidth-1:0] x_i,
  input  logic signed [pse_pkg::CoefWidth-1:0] term_i,
  output logic signed [pse_pkg::AccWidth-1:0]  acc_o,
  output logic                                 sat_o
);

  import pse_pkg::*;

  logic signed [AccWidth-1:0] acc_q;
  logic [CoefWidth-1:0]       xm_q;
  logic                       xneg_q;
  logic [AccWidth-1:0]        am_q;
  logic                       neg_q;
  logic [AccWidth-1:0]        plo_q;
  logic [AccWidth-1:0]        phi_q;
  logic signed [AccWidth-1:0] prod_q;
  logic                       sat_q;

  logic [AccWidth-1:0]        acc_mag;
  logic [CoefWidth-1:0]       x_mag;
  logic [AccWidth-1:0]        plo_rnd;
  logic [AccWidth-1:0]        r_mag;
  logic                       hi_ovf;
  logic                       min_ok;
  logic                       rnd_sat;
  logic signed [AccWidth-1:0] rnd_val;
  logic signed [AccWidth:0]   sum;
  logic                       add_ovf;
  logic signed [AccWidth-1:0] add_val;

  // magnitudes, rounded Q16 product and saturating accumulate
  always_comb begin
    acc_mag = acc_q[AccWidth-1] ? (AccWidth'(0) - unsigned'(acc_q)) : unsigned'(acc_q);
    x_mag   = x_i[CoefWidth-1] ? (CoefWidth'(0) - unsigned'(x_i)) : unsigned'(x_i);
    plo_rnd = plo_q + 64'h8000;
    r_mag   = {phi_q[47:0], 16'h0000} + {16'h0000, plo_rnd[63:16]};
    hi_ovf  = |phi_q[63:47];
    min_ok  = neg_q && (r_mag == {1'b1, 63'd0});
    rnd_sat = hi_ovf || (r_mag[63] && !min_ok);
    if (rnd_sat) begin
      rnd_val = neg_q ? AccMin : AccMax;
    end else begin
      rnd_val = neg_q ? signed'(AccWidth'(0) - r_mag) : signed'(r_mag);
    end
    sum     = {prod_q[AccWidth-1], prod_q} + {{(AccWidth-CoefWidth+1){term_i[CoefWidth-1]}}, term_i};
    add_ovf = sum[AccWidth] ^ sum[AccWidth-1];
    add_val = add_ovf ? (sum[AccWidth] ? AccMin : AccMax) : sum[AccWidth-1:0];
  end

  // step datapath, one stage per strobe
  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      acc_q  <= '0;
      xm_q   <= x_mag;
      xneg_q <= x_i[CoefWidth-1];
    end else if (ctrl_i.add_en) begin
      acc_q  <= add_val;
    end
    if (ctrl_i.mag_en) begin
      am_q  <= acc_mag;
      neg_q <= acc_q[AccWidth-1] ^ xneg_q;
    end
    if (ctrl_i.mul_en) begin
      plo_q <= AccWidth'(am_q[31:0]) * AccWidth'(xm_q);
      phi_q <= AccWidth'(am_q[63:32]) * AccWidth'(xm_q);
    end
    if (ctrl_i.rnd_en) prod_q <= rnd_val;
  end

  // sticky clamp flag over the whole item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (ctrl_i.clr_sat) begin
      sat_q <= 1'b0;
    end else if ((ctrl_i.rnd_en && rnd_sat) || (ctrl_i.add_en && add_ovf)) begin
      sat_q <= 1'b1;
    end
  end

  assign acc_o = acc_q;
  assign sat_o = sat_q;

endmodule

// ===== design/polynomial_store_evaluator.sv =====
// Polynomial coefficient store with Horner evaluation and definite integral.
// Input stream: s_axis_tuser carries the item kind, s_axis_tdata the exponent,
// amount and two Q16.16 points. Every accepted beat yields exactly one result
// beat on m_axis with the value, the degree after the item, a zero flag and a
// saturation flag. One item is in work at a time; s_axis_tready is high only
// while the block waits for an item, and a finished result sits in the output
// register so the next item is taken while the receiver has not yet read it.
// s_axis_tready rises again in the cycle after a result is loaded into the
// output register. Each Horner step runs through ST_MAG, ST_MUL, ST_RND,
// ST_DIV and ST_ADD: coefficient read from the store, split 64x32 product,
// rounding, antiderivative divide and accumulate. Reset empties the store
// at once through per-entry valid bits and sets the degree to 0. When
// m_axis_tready is low the result beat holds and the block stalls once the
// next result is ready.
module polynomial_store_evaluator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [4:0] exponent, [36:5] amount, [68:37] point_a, [100:69] point_b, rest zero
  input  logic [pse_pkg::InDataWidth-1:0]   s_axis_tdata,
  // [2:0] kind
  input  logic [pse_pkg::KindWidth-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] result_value, [36:32] poly_degree, [37] zero_poly, [38] saturated,
  // [39] zero
  output logic [pse_pkg::OutDataWidth-1:0]  m_axis_tdata
);

  import pse_pkg::*;

  pse_state_e state_q, state_d;

  // item fields
  kind_t                       kind_q;
  logic [ExpWidth-1:0]         exp_q;
  logic signed [CoefWidth-1:0] amount_q;
  logic signed [CoefWidth-1:0] pa_q;
  logic signed [CoefWidth-1:0] pb_q;

  // store status
  logic [StoreDepth-1:0] valid_q;
  logic [StoreDepth-1:0] nz_q;
  logic [ExpWidth-1:0]   degree_q;

  // sequencer and result
  logic [KWidth-1:0]           k_q;
  logic                        pass_q;
  logic                        rvalid_q;
  logic signed [CoefWidth-1:0] coef_q;
  logic signed [AccWidth-1:0]  fb_q;
  logic signed [CoefWidth-1:0] res_q;
  logic                        sat_q;
  logic                        out_valid_q;
  logic [OutDataWidth-1:0]     out_data_q;

  logic                        accept;
  logic                        out_free;
  logic                        is_eval;
  logic                        is_integ;
  logic [KWidth-1:0]           k_dec;
  logic                        mem_we;
  logic                        mem_re;
  logic [ExpWidth-1:0]         mem_waddr;
  logic [ExpWidth-1:0]         mem_raddr;
  logic [CoefWidth-1:0]        mem_wdata;
  logic [CoefWidth-1:0]        mem_rdata;
  logic signed [CoefWidth-1:0] rd_coef;
  logic signed [CoefWidth:0]   wb_sum;
  logic                        wb_ovf;
  logic signed [CoefWidth-1:0] wb_val;
  logic signed [AccWidth:0]    fin_src;
  logic                        fin_fits;
  logic signed [CoefWidth-1:0] fin_val;
  logic signed [CoefWidth-1:0] x_sel;
  logic signed [CoefWidth-1:0] term;
  logic signed [CoefWidth-1:0] div_term;
  logic signed [AccWidth-1:0]  acc;
  logic                        mac_sat;
  mac_ctrl_t                   mac_ctrl;
  div_ctrl_t                   div_ctrl;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign is_eval  = (kind_q == KindEval);
  assign is_integ = (kind_q == KindInteg);
  assign k_dec    = k_q - KWidth'(1);

  // datapath arithmetic
  always_comb begin
    rd_coef  = rvalid_q ? signed'(mem_rdata) : '0;
    wb_sum   = {rd_coef[CoefWidth-1], rd_coef} + {amount_q[CoefWidth-1], amount_q};
    wb_ovf   = wb_sum[CoefWidth] ^ wb_sum[CoefWidth-1];
    wb_val   = wb_ovf ? (wb_sum[CoefWidth] ? CoefMin : CoefMax) : wb_sum[CoefWidth-1:0];
    fin_src  = is_integ ? ({fb_q[AccWidth-1], fb_q} - {acc[AccWidth-1], acc})
                        : {acc[AccWidth-1], acc};
    fin_fits = (&fin_src[AccWidth:CoefWidth-1]) || !(|fin_src[AccWidth:CoefWidth-1]);
    fin_val  = fin_fits ? fin_src[CoefWidth-1:0] : (fin_src[AccWidth] ? CoefMin : CoefMax);
    x_sel    = (is_eval || pass_q) ? pa_q : pb_q;
    term     = is_eval ? coef_q : ((k_q == '0) ? '0 : div_term);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_DISP;
      ST_DISP: begin
        unique case (kind_q) inside
          KindAssign, KindClear: state_d = ST_DEG;
          KindAdd:               state_d = ST_WB;
          KindEval, KindInteg:   state_d = ST_PASS;
          KindRead:              state_d = ST_RDW;
          default:               state_d = ST_DONE;
        endcase
      end
      ST_RDW:  state_d = ST_DONE;
      ST_WB:   state_d = ST_DEG;
      ST_DEG:  state_d = ST_DONE;
      ST_PASS: state_d = ST_MAG;
      ST_MAG:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_RND;
      ST_RND:  state_d = ST_DIV;
      ST_DIV:  state_d = ST_ADD;
      ST_ADD:  state_d = (k_q == '0) ? ST_FIN : ST_MAG;
      ST_FIN:  state_d = (is_integ && !pass_q) ? ST_PASS : ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs: handshake, store port and engine strobes
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = exp_q;
    mem_raddr     = exp_q;
    mem_wdata     = amount_q;
    mac_ctrl      = '0;
    div_ctrl      = '0;
    mac_ctrl.clr_sat = accept;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_DISP: begin
        mem_we = (kind_q == KindAssign);
        mem_re = (kind_q == KindAdd) || (kind_q == KindRead);
      end
      ST_WB: begin
        mem_we    = 1'b1;
        mem_wdata = wb_val;
      end
      ST_PASS: mac_ctrl.init = 1'b1;
      ST_MAG: begin
        mac_ctrl.mag_en = 1'b1;
        mem_re          = 1'b1;
        mem_raddr       = is_eval ? k_q[ExpWidth-1:0] : k_dec[ExpWidth-1:0];
      end
      ST_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        div_ctrl.ld     = 1'b1;
      end
      ST_RND: begin
        mac_ctrl.rnd_en = 1'b1;
        div_ctrl.mul    = 1'b1;
      end
      ST_DIV:  div_ctrl.fix = 1'b1;
      ST_ADD:  mac_ctrl.add_en = 1'b1;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // item capture and sequencer registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= s_axis_tuser;
      exp_q    <= s_axis_tdata[ExpWidth-1:0];
      amount_q <= s_axis_tdata[InAmtLsb +: CoefWidth];
      pa_q     <= s_axis_tdata[InPaLsb +: CoefWidth];
      pb_q     <= s_axis_tdata[InPbLsb +: CoefWidth];
    end
    if (mem_re) rvalid_q <= valid_q[mem_raddr];
    if (state_q == ST_PASS) k_q <= is_eval ? {1'b0, degree_q} : ({1'b0, degree_q} + KWidth'(1));
    if (state_q == ST_ADD && k_q != '0) k_q <= k_dec;
    if (state_q == ST_MUL) coef_q <= rd_coef;
    if (state_q == ST_FIN && is_integ && !pass_q) fb_q <= acc;
    if (state_q == ST_DISP) res_q <= '0;
    if (state_q == ST_RDW) res_q <= rd_coef;
    if (state_q == ST_FIN) res_q <= fin_val;
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= {{(OutDataWidth-OutSatBit-1){1'b0}}, sat_q, ~|nz_q, degree_q, res_q};
    end
  end

  // store status, pass select and clamp flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      nz_q     <= '0;
      degree_q <= '0;
      pass_q   <= 1'b0;
      sat_q    <= 1'b0;
    end else begin
      if (accept) begin
        pass_q <= 1'b0;
        sat_q  <= 1'b0;
      end
      if (state_q == ST_DISP && kind_q == KindClear) begin
        valid_q <= '0;
        nz_q    <= '0;
      end
      if (mem_we) begin
        valid_q[mem_waddr] <= 1'b1;
        nz_q[mem_waddr]    <= (mem_wdata != '0);
      end
      if (state_q == ST_WB && wb_ovf) sat_q <= 1'b1;
      if (state_q == ST_DEG) degree_q <= top_index(nz_q);
      if (state_q == ST_FIN) begin
        if (is_integ && !pass_q) pass_q <= 1'b1;
        else                     sat_q  <= sat_q | mac_sat | !fin_fits;
      end
    end
  end

  // result register towards the receiver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  pse_ram #(
    .Depth (StoreDepth),
    .Width (CoefWidth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pse_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .x_i    (x_sel),
    .term_i (term),
    .acc_o  (acc),
    .sat_o  (mac_sat)
  );

  pse_div u_div (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .coef_i (rd_coef),
    .k_i    (k_q),
    .term_o (div_term)
  );

endmodule

// ===== design/pse_chk.sv =====
module pse_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [pse_pkg::InDataWidth-1:0]  s_axis_tdata,
  input logic [pse_pkg::KindWidth-1:0]    s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [pse_pkg::OutDataWidth-1:0] m_axis_tdata
);

  import pse_pkg::*;

  logic s_beat;
  assign s_beat = s_axis_tvalid && s_axis_tready;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed under stall");

  // a zero polynomial always reports degree 0
  a_zero_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OutZeroBit] |->
      m_axis_tdata[OutDegLsb +: ExpWidth] == '0)
    else $error("zero polynomial with nonzero degree");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // no result can appear in the cycle after an accept
  a_min_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat |=> !$rose(m_axis_tvalid))
    else $error("result beat too early after accept");

endmodule

bind polynomial_store_evaluator pse_chk u_pse_chk (.*);
